>>> rtl/rect_split_around_cut_unit_assert.svh
// Assertion macros for the rectangle split unit.
`ifndef RECT_SPLIT_AROUND_CUT_UNIT_ASSERT_SVH
`define RECT_SPLIT_AROUND_CUT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define RSAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSAC_ASSERT(lbl, prop, msg)
`define RSAC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/rsac_pkg.sv
// Types and constants shared by the rectangle split unit.
`timescale 1ns / 1ps
`default_nettype none
package rsac_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned NUM_PIECES = 4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t subject_top;
    coord_t subject_left;
    coord_t subject_bottom;
    coord_t subject_right;
    coord_t cut_top;
    coord_t cut_left;
    coord_t cut_bottom;
    coord_t cut_right;
  } in_t;

  typedef struct packed {
    coord_t piece_top;
    coord_t piece_left;
    coord_t piece_bottom;
    coord_t piece_right;
    logic   piece_valid;
    logic   last_piece;
  } out_t;

  typedef logic [NUM_PIECES-1:0] piece_mask_t;

endpackage
`default_nettype wire

>>> rtl/rect_split_around_cut_unit.sv
// Rectangle split unit: pieces of a subject rectangle lying outside a cut.
`timescale 1ns / 1ps
`default_nettype none
`include "rect_split_around_cut_unit_assert.svh"

// Takes one subject/cut pair per input beat and returns the left, top, right
// and bottom strips of the subject outside the cut, in that order, one result
// beat per cycle while out_ready is high, through a registered output; the
// final beat of each run has last_piece set, and a pair that yields no strip
// gives one beat with piece_valid clear. An item stays in the input register
// until its last result beat (of 1 to 4) moves to the single result register;
// the next item is taken in the cycle its last beat moves to the output, so a
// new pair is accepted while the last beat of the previous one goes out. Each
// input beat is registered first in item_r and each result beat then in out_r.
module rect_split_around_cut_unit
  import rsac_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  in_t         item_r;
  logic        item_v_r;
  piece_mask_t done_r;
  out_t        out_r;
  logic        out_v_r;

  // strip evaluation on the held item
  coord_t      l1, t1, r1;
  piece_mask_t fire;
  out_t        piece [NUM_PIECES];

  always_comb begin
    fire[0] = (item_r.cut_left > item_r.subject_left) &&
              (item_r.cut_left <= item_r.subject_right);
    l1 = fire[0] ? item_r.cut_left : item_r.subject_left;
    fire[1] = (item_r.cut_top > item_r.subject_top) &&
              (item_r.cut_top <= item_r.subject_bottom);
    t1 = fire[1] ? item_r.cut_top : item_r.subject_top;
    fire[2] = (item_r.cut_right >= l1) && (item_r.cut_right < item_r.subject_right);
    r1 = fire[2] ? item_r.cut_right : item_r.subject_right;
    fire[3] = (item_r.cut_bottom >= t1) && (item_r.cut_bottom < item_r.subject_bottom);

    piece[0] = '{piece_top: item_r.subject_top, piece_left: item_r.subject_left,
                 piece_bottom: item_r.subject_bottom,
                 piece_right: coord_t'(item_r.cut_left - coord_t'(1)),
                 piece_valid: 1'b1, last_piece: 1'b0};
    piece[1] = '{piece_top: item_r.subject_top, piece_left: l1,
                 piece_bottom: coord_t'(item_r.cut_top - coord_t'(1)),
                 piece_right: item_r.subject_right,
                 piece_valid: 1'b1, last_piece: 1'b0};
    piece[2] = '{piece_top: t1, piece_left: coord_t'(item_r.cut_right + coord_t'(1)),
                 piece_bottom: item_r.subject_bottom, piece_right: item_r.subject_right,
                 piece_valid: 1'b1, last_piece: 1'b0};
    piece[3] = '{piece_top: coord_t'(item_r.cut_bottom + coord_t'(1)), piece_left: l1,
                 piece_bottom: item_r.subject_bottom, piece_right: r1,
                 piece_valid: 1'b1, last_piece: 1'b0};
  end

  // pick the earliest strip not yet sent
  piece_mask_t remaining, sel;
  logic        is_last;
  logic        out_load;
  out_t        beat;

  always_comb begin
    remaining = fire & ~done_r;
    sel       = remaining & (~remaining + piece_mask_t'(1));
    is_last   = (remaining & (remaining - piece_mask_t'(1))) == '0;
    beat      = '0;
    beat.last_piece = 1'b1;
    if (sel[0]) begin
      beat = piece[0];
    end else if (sel[1]) begin
      beat = piece[1];
    end else if (sel[2]) begin
      beat = piece[2];
    end else if (sel[3]) begin
      beat = piece[3];
    end
    beat.last_piece = is_last;
  end

  assign out_load  = item_v_r && (!out_v_r || out_ready);
  assign in_ready  = !item_v_r || (out_load && is_last);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  piece_mask_t done_nxt;
  logic        item_v_nxt;
  logic        out_v_nxt;

  always_comb begin
    done_nxt   = done_r;
    item_v_nxt = item_v_r;
    out_v_nxt  = out_v_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (out_load) begin
      out_v_nxt = 1'b1;
      if (is_last) begin
        item_v_nxt = 1'b0;
        done_nxt   = '0;
      end else begin
        done_nxt = done_r | sel;
      end
    end
    if (in_valid && in_ready) begin
      item_v_nxt = 1'b1;
      done_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      done_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      done_r   <= done_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_r <= beat;
    end
  end

  `RSAC_ASSERT(a_item_kept, item_v_r && out_load && !is_last |=> item_v_r, "item dropped before last beat")
  `RSAC_ASSERT(a_empty_is_last, out_v_r && !out_r.piece_valid |-> out_r.last_piece, "empty result not marked last")
  `RSAC_ASSERT(a_done_subset, item_v_r |-> (done_r & ~fire) == '0, "sent mask outside fired strips")
  `RSAC_ASSERT(a_accept_clears, in_valid && in_ready |=> done_r == '0, "sent mask not cleared on new item")
  `RSAC_ASSERT_ALWAYS(a_idle_clean, !item_v_r |-> done_r == '0, "sent mask set with no item held")

endmodule
`default_nettype wire

>>> test/tb_rect_split_around_cut_unit.sv
// Testbench for the rectangle split unit: directed and random subject/cut pairs against a predictor.
`timescale 1ns / 1ps
module tb_rect_split_around_cut_unit;
  import rsac_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLDOFF_LEN  = 400;
  localparam int TAIL_CYCLES  = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  out_t pieces_expected[$];
  int   sender_idle_pct = 35;
  int   receiver_idle_pct = 35;
  bit   holdoff_req = 1'b0;
  int   holdoff_left = 0;
  int   error_count = 0;
  int   pairs_accepted = 0;
  int   beats_checked = 0;
  int   empty_beats = 0;
  int   stall_cycles = 0;

  rect_split_around_cut_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_t strip(coord_t t, coord_t l, coord_t b, coord_t r);
    return '{t, l, b, r, 1'b1, 1'b0};
  endfunction

  // Left, top, right, bottom; each step tests the working copy left by the earlier ones.
  function automatic void predict_pieces(in_t pair);
    coord_t t, l, b, r, ct, cl, cb, cr;
    int n;
    t  = pair.subject_top;
    l  = pair.subject_left;
    b  = pair.subject_bottom;
    r  = pair.subject_right;
    ct = pair.cut_top;
    cl = pair.cut_left;
    cb = pair.cut_bottom;
    cr = pair.cut_right;
    n  = 0;
    if (cl > l && cl <= r) begin
      pieces_expected.push_back(strip(t, l, b, coord_t'(cl - 1)));
      l = cl;
      n++;
    end
    if (ct > t && ct <= b) begin
      pieces_expected.push_back(strip(t, l, coord_t'(ct - 1), r));
      t = ct;
      n++;
    end
    if (cr >= l && cr < r) begin
      pieces_expected.push_back(strip(t, coord_t'(cr + 1), b, r));
      r = cr;
      n++;
    end
    if (cb >= t && cb < b) begin
      pieces_expected.push_back(strip(coord_t'(cb + 1), l, b, r));
      b = cb;
      n++;
    end
    if (n == 0)
      pieces_expected.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1});
    else
      pieces_expected[pieces_expected.size() - 1].last_piece = 1'b1;
  endfunction

  function automatic in_t make_pair(int t, int l, int b, int r,
                                    int ct, int cl, int cb, int cr);
    return '{coord_t'(t), coord_t'(l), coord_t'(b), coord_t'(r),
             coord_t'(ct), coord_t'(cl), coord_t'(cb), coord_t'(cr)};
  endfunction

  function automatic int rnd_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Leaves in_valid high on return so a following beat can go out back to back.
  task automatic send_pair(in_t pair);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    do @(posedge clk); while (!in_ready);
    predict_pieces(pair);
    pairs_accepted++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pieces_expected.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_LEN;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (!out_data.piece_valid) empty_beats++;
      if (pieces_expected.size() == 0) begin
        $error("result beat with nothing pending: %p", out_data);
        error_count++;
      end else begin
        want = pieces_expected.pop_front();
        if (out_data.piece_top !== want.piece_top) begin
          $error("piece_top: expected %0d, got %0d", want.piece_top, out_data.piece_top);
          error_count++;
        end
        if (out_data.piece_left !== want.piece_left) begin
          $error("piece_left: expected %0d, got %0d", want.piece_left, out_data.piece_left);
          error_count++;
        end
        if (out_data.piece_bottom !== want.piece_bottom) begin
          $error("piece_bottom: expected %0d, got %0d",
                 want.piece_bottom, out_data.piece_bottom);
          error_count++;
        end
        if (out_data.piece_right !== want.piece_right) begin
          $error("piece_right: expected %0d, got %0d", want.piece_right, out_data.piece_right);
          error_count++;
        end
        if (out_data.piece_valid !== want.piece_valid) begin
          $error("piece_valid: expected %0b, got %0b", want.piece_valid, out_data.piece_valid);
          error_count++;
        end
        if (out_data.last_piece !== want.last_piece) begin
          $error("last_piece: expected %0b, got %0b", want.last_piece, out_data.last_piece);
          error_count++;
        end
      end
    end
  end

  // Ends the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_strips();
    send_pair(make_pair(0, 0, 9, 9, 3, 3, 6, 6));
    send_pair(make_pair(0, 0, 9, 9, -5, 4, 20, 20));
    send_pair(make_pair(0, 0, 9, 9, 4, -5, 20, 20));
    send_pair(make_pair(0, 0, 9, 9, -5, -5, 20, 5));
    send_pair(make_pair(0, 0, 9, 9, -5, -5, 5, 20));
    // left and right fire although the cut rows miss the subject entirely
    send_pair(make_pair(0, 0, 9, 9, 100, 5, 200, 5));
  endtask

  task automatic test_no_piece();
    send_pair(make_pair(0, 0, 9, 9, -1, -1, 10, 10));
    send_pair(make_pair(0, 0, 9, 9, 0, 20, 9, 30));
    send_pair(make_pair(0, 0, 9, 9, 0, 0, 9, 9));
    send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  task automatic test_extremes();
    send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32768, -32768, -32768));
    send_pair(make_pair(-32768, -32768, 32767, 32767, 0, 0, 0, 0));
    send_pair(make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    send_pair(make_pair(-300, 17, 4000, 90, -32768, -32768, 32767, 32767));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32767, -32767, 32766, 32766));
  endtask

  task automatic test_inverted();
    send_pair(make_pair(9, 0, 0, 9, 3, 3, 6, 6));
    send_pair(make_pair(0, 9, 9, 0, 3, 3, 6, 6));
    send_pair(make_pair(9, 9, 0, 0, 3, 3, 6, 6));
    send_pair(make_pair(0, 0, 9, 9, 6, 6, 3, 3));
  endtask

  // Mostly small subjects with cut edges near them; some fully random and inverted pairs.
  task automatic test_random_pairs(int count);
    int sel, t, l, b, r, swap;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      if (sel >= 8) begin
        send_pair(in_t'({$urandom, $urandom, $urandom, $urandom}));
      end else begin
        t = rnd_between(-32768, 32767 - 40);
        l = rnd_between(-32768, 32767 - 40);
        b = t + rnd_between(0, 30);
        r = l + rnd_between(0, 30);
        if (sel >= 6) begin
          swap = t; t = b; b = swap;
        end
        if (sel == 7) begin
          swap = l; l = r; r = swap;
        end
        send_pair(make_pair(t, l, b, r,
                            rnd_between(-32768, 32767 - 80) * (sel == 5) + (sel != 5) *
                              (((t < b) ? t : b) + rnd_between(-8, 38)),
                            ((l < r) ? l : r) + rnd_between(-8, 38),
                            ((t < b) ? t : b) + rnd_between(-8, 38),
                            ((l < r) ? l : r) + rnd_between(-8, 38)));
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_pairs(count);
    wait_for_results();
    sender_idle_pct   = 35;
    receiver_idle_pct = 35;
  endtask

  // Output held off while input keeps offering, so the unit fills and drops in_ready.
  task automatic test_receiver_holdoff(int count);
    sender_idle_pct = 0;
    holdoff_req = 1'b1;
    test_random_pairs(count);
    wait_for_results();
    sender_idle_pct = 35;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_strips();
    test_no_piece();
    test_extremes();
    test_inverted();
    wait_for_results();
    test_random_pairs(110);
    wait_for_results();
    test_back_to_back(60);
    test_receiver_holdoff(30);
    test_random_pairs(90);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d subject/cut pairs (strips, no-piece, extremes, inverted, random).",
             pairs_accepted);
    $display("Checked %0d result beats, %0d of them empty.", beats_checked, empty_beats);
    if (error_count == 0 && pieces_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
